// ----- hdl/rbd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package rbd_pkg;

  // Fixed limits of the block
  localparam int MaxFactor  = 16;
  localparam int MaxOutLine = 256;
  localparam int OuterLimit = 4096;

  localparam int FactW  = 5;   // scale factor register width
  localparam int OcntW  = 13;  // outer count register width
  localparam int IcntW  = 9;   // inner count register width
  localparam int CfgW   = 13;  // widest register
  localparam int CfgIdxW = 2;
  localparam int ColW   = $clog2(MaxOutLine);
  localparam int RowW   = 12;
  localparam int InIdxW = 12;  // source pixel index along the line
  localparam int OutIdxW = 16; // source line index
  localparam int SubW   = 4;   // position inside a block
  localparam int SumW   = 16;
  localparam int RecipW = 25;
  localparam int AreaW  = 9;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegScale    = 2'd0;
  localparam logic [CfgIdxW-1:0] RegOutOuter = 2'd1;
  localparam logic [CfgIdxW-1:0] RegOutInner = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_READ,
    S_SUM,
    S_MUL,
    S_CORR
  } state_e;

  typedef struct packed {
    logic accept;
    logic rd_en;
    logic sum_en;
    logic mul_en;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic dirty;
    logic div_done;
    logic block_end;
    logic out_free;
  } sts_t;

  // floor(2^24 / (f*f)) for each factor
  function automatic logic [RecipW-1:0] recip(input logic [FactW-1:0] f);
    logic [RecipW-1:0] m;
    case (f)
      5'd1:    m = 25'd16777216;
      5'd2:    m = 25'd4194304;
      5'd3:    m = 25'd1864135;
      5'd4:    m = 25'd1048576;
      5'd5:    m = 25'd671088;
      5'd6:    m = 25'd466033;
      5'd7:    m = 25'd342392;
      5'd8:    m = 25'd262144;
      5'd9:    m = 25'd207126;
      5'd10:   m = 25'd167772;
      5'd11:   m = 25'd138654;
      5'd12:   m = 25'd116508;
      5'd13:   m = 25'd99273;
      5'd14:   m = 25'd85598;
      5'd15:   m = 25'd74565;
      5'd16:   m = 25'd65536;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/rbd_idxdiv.sv -----
`timescale 1ns / 1ps
`default_nettype none
module rbd_idxdiv (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [rbd_pkg::OutIdxW-1:0] dvd_a_i,
  input  wire logic [rbd_pkg::OutIdxW-1:0] dvd_b_i,
  input  wire logic [rbd_pkg::FactW-1:0]   dvs_i,
  output logic      [rbd_pkg::OutIdxW-1:0] quot_a_o,
  output logic      [rbd_pkg::SubW-1:0]    rem_a_o,
  output logic      [rbd_pkg::OutIdxW-1:0] quot_b_o,
  output logic      [rbd_pkg::SubW-1:0]    rem_b_o,
  output logic                             done_o
);
  import rbd_pkg::*;

  localparam int CntW = $clog2(OutIdxW);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [OutIdxW-1:0]  wa_q, wa_d, wb_q, wb_d;
  logic [SubW-1:0]     ra_q, ra_d, rb_q, rb_d;
  logic [SubW:0]       ta, tb;

  // One quotient bit per lane and cycle, restoring form
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    wa_d   = wa_q;
    wb_d   = wb_q;
    ra_d   = ra_q;
    rb_d   = rb_q;
    ta     = {ra_q, wa_q[OutIdxW-1]};
    tb     = {rb_q, wb_q[OutIdxW-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      wa_d   = dvd_a_i;
      wb_d   = dvd_b_i;
      ra_d   = '0;
      rb_d   = '0;
    end else if (busy_q) begin
      if (ta >= dvs_i) begin
        ra_d = SubW'(ta - dvs_i);
        wa_d = {wa_q[OutIdxW-2:0], 1'b1};
      end else begin
        ra_d = ta[SubW-1:0];
        wa_d = {wa_q[OutIdxW-2:0], 1'b0};
      end
      if (tb >= dvs_i) begin
        rb_d = SubW'(tb - dvs_i);
        wb_d = {wb_q[OutIdxW-2:0], 1'b1};
      end else begin
        rb_d = tb[SubW-1:0];
        wb_d = {wb_q[OutIdxW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(OutIdxW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wa_q <= wa_d;
    wb_q <= wb_d;
    ra_q <= ra_d;
    rb_q <= rb_d;
  end

  assign quot_a_o = wa_q;
  assign quot_b_o = wb_q;
  assign rem_a_o  = ra_q;
  assign rem_b_o  = rb_q;
  assign done_o   = done_q;

`ifndef SYNTHESIS
  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> ({1'b0, ra_q} < dvs_i && {1'b0, rb_q} < dvs_i))
    else $error("index divider remainder not below divisor");
`endif

endmodule
`default_nettype wire

// ----- hdl/rbd_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
module rbd_dp (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire rbd_pkg::cmd_t               cmd_i,
  output rbd_pkg::sts_t                    sts_o,
  input  wire logic [7:0]                  pixel_red_i,
  input  wire logic [7:0]                  pixel_green_i,
  input  wire logic [7:0]                  pixel_blue_i,
  input  wire logic                        frame_start_i,
  input  wire logic                        cfg_we_i,
  input  wire logic [rbd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [rbd_pkg::CfgW-1:0]    cfg_data_i,
  input  wire logic                        out_ready_i,
  output logic                             out_valid_o,
  output logic      [7:0]                  avg_red_o,
  output logic      [7:0]                  avg_green_o,
  output logic      [7:0]                  avg_blue_o,
  output logic      [11:0]                 out_outer_pos_o,
  output logic      [7:0]                  out_inner_pos_o,
  output logic                             frame_done_o
);
  import rbd_pkg::*;

  // Configuration registers
  logic [FactW-1:0] scale_q;
  logic [OcntW-1:0] ocnt_q;
  logic [IcntW-1:0] icnt_q;
  logic             dirty_q;

  // Effective settings
  logic [FactW-1:0] f_eff;
  logic [SubW-1:0]  f_last;
  logic [OcntW-1:0] n_outer;
  logic [IcntW-1:0] n_inner;
  logic [InIdxW:0]  in_ext;
  logic [OutIdxW:0] out_ext;
  logic [AreaW-1:0] area;

  // Position state
  logic [InIdxW-1:0]  iidx_q;
  logic [OutIdxW-1:0] oidx_q;
  logic [SubW-1:0]    subc_q, subr_q;
  logic [ColW-1:0]    col_q;
  logic [RowW-1:0]    row_q;
  logic               izero, ozero;
  logic [InIdxW:0]    iidx_nx;
  logic [OutIdxW:0]   oidx_nx;
  logic               block_end;

  // Divider
  logic               div_start;
  logic [OutIdxW-1:0] div_qa, div_qb;
  logic [SubW-1:0]    div_ra, div_rb;
  logic               div_done;

  // Sum line
  logic [3*SumW-1:0]    sums_mem [MaxOutLine];
  logic [MaxOutLine-1:0] vld_q;
  logic [2:0][SumW-1:0]  rd_q;
  logic                  rd_vld_q;
  logic [2:0][7:0]       pix_q;
  logic [2:0][SumW-1:0]  acc;
  logic [2:0][SumW:0]    acc_w;
  logic [2:0][SumW-1:0]  sum_q;
  logic [2:0][SumW-1:0]  q0_q;
  logic [2:0][SumW+RecipW-1:0] prod;
  logic [2:0][SumW+AreaW-1:0]  back;
  logic [2:0][SumW:0]    rem;
  logic [2:0][SumW:0]    qc;
  logic [2:0][7:0]       avg;
  logic [RecipW-1:0]     mrec;

  // Output register
  logic            out_valid_q;
  logic [2:0][7:0] avg_q;
  logic [RowW-1:0] opos_q, res_row_q;
  logic [ColW-1:0] ipos_q, res_col_q;
  logic            fdone_q, res_fdone_q;
  logic            out_free;

  // Clamp register values into their ranges
  always_comb begin
    if (scale_q == '0)                       f_eff = FactW'(1);
    else if (scale_q > FactW'(MaxFactor))    f_eff = FactW'(MaxFactor);
    else                                     f_eff = scale_q;
    if (ocnt_q == '0)                        n_outer = OcntW'(1);
    else if (ocnt_q > OcntW'(OuterLimit))    n_outer = OcntW'(OuterLimit);
    else                                     n_outer = ocnt_q;
    if (icnt_q == '0)                        n_inner = IcntW'(1);
    else if (icnt_q > IcntW'(MaxOutLine))    n_inner = IcntW'(MaxOutLine);
    else                                     n_inner = icnt_q;
  end

  assign f_last  = SubW'(f_eff - 1'b1);
  assign in_ext  = (InIdxW+1)'(n_inner * f_eff);
  assign out_ext = (OutIdxW+1)'(n_outer * f_eff);
  assign area    = AreaW'(f_eff * f_eff);
  assign mrec    = recip(f_eff);

  // Registers and dirty mark for the stored quotients
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= FactW'(1);
      ocnt_q  <= OcntW'(64);
      icnt_q  <= IcntW'(64);
      dirty_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegScale:    scale_q <= cfg_data_i[FactW-1:0];
          RegOutOuter: ocnt_q  <= cfg_data_i[OcntW-1:0];
          RegOutInner: icnt_q  <= cfg_data_i[IcntW-1:0];
          default: ;
        endcase
      end
      if (cfg_we_i && cfg_index_i == RegScale) dirty_q <= 1'b1;
      else if (div_done)                       dirty_q <= 1'b0;
    end
  end

  // Zero indices on frame start or when beyond the current extent
  assign izero = frame_start_i || ({1'b0, iidx_q} >= in_ext);
  assign ozero = frame_start_i || ({1'b0, oidx_q} >= out_ext);
  assign div_start = cmd_i.accept && dirty_q;

  rbd_idxdiv u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .dvd_a_i  (ozero ? '0 : oidx_q),
    .dvd_b_i  (izero ? '0 : OutIdxW'(iidx_q)),
    .dvs_i    (f_eff),
    .quot_a_o (div_qa),
    .rem_a_o  (div_ra),
    .quot_b_o (div_qb),
    .rem_b_o  (div_rb),
    .done_o   (div_done)
  );

  assign block_end = (subc_q == f_last) && (subr_q == f_last);
  assign iidx_nx   = iidx_q + 1'b1;
  assign oidx_nx   = oidx_q + 1'b1;

  // Track indices and their quotient and remainder by the factor
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iidx_q <= '0;
      oidx_q <= '0;
      subc_q <= '0;
      subr_q <= '0;
      col_q  <= '0;
      row_q  <= '0;
    end else if (cmd_i.accept) begin
      if (izero) begin
        iidx_q <= '0;
        subc_q <= '0;
        col_q  <= '0;
      end
      if (ozero) begin
        oidx_q <= '0;
        subr_q <= '0;
        row_q  <= '0;
      end
    end else if (div_done) begin
      col_q  <= div_qb[ColW-1:0];
      subc_q <= div_rb;
      row_q  <= div_qa[RowW-1:0];
      subr_q <= div_ra;
    end else if (cmd_i.sum_en) begin
      if (iidx_nx >= in_ext) begin
        iidx_q <= '0;
        subc_q <= '0;
        col_q  <= '0;
        if (oidx_nx >= out_ext) begin
          oidx_q <= '0;
          subr_q <= '0;
          row_q  <= '0;
        end else begin
          oidx_q <= oidx_nx[OutIdxW-1:0];
          if (subr_q == f_last) begin
            subr_q <= '0;
            row_q  <= row_q + 1'b1;
          end else begin
            subr_q <= subr_q + 1'b1;
          end
        end
      end else begin
        iidx_q <= iidx_nx[InIdxW-1:0];
        if (subc_q == f_last) begin
          subc_q <= '0;
          col_q  <= col_q + 1'b1;
        end else begin
          subc_q <= subc_q + 1'b1;
        end
      end
    end
  end

  // Entry valid bits: drop all on frame start, set one on a partial sum, drop one at block end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (cmd_i.accept && frame_start_i) begin
      vld_q <= '0;
    end else if (cmd_i.sum_en) begin
      vld_q[col_q] <= !block_end;
    end
  end

  // Sum line memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.sum_en && !block_end) sums_mem[col_q] <= acc;
    if (cmd_i.rd_en) begin
      rd_q     <= sums_mem[col_q];
      rd_vld_q <= vld_q[col_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) pix_q <= {pixel_blue_i, pixel_green_i, pixel_red_i};
  end

  // Saturating accumulate per channel
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      acc_w[c] = (rd_vld_q ? {1'b0, rd_q[c]} : '0) + (SumW+1)'(pix_q[c]);
      acc[c]   = acc_w[c][SumW] ? {SumW{1'b1}} : acc_w[c][SumW-1:0];
    end
  end

  // Capture the finished block
  always_ff @(posedge clk_i) begin
    if (cmd_i.sum_en && block_end) begin
      sum_q       <= acc;
      res_row_q   <= row_q;
      res_col_q   <= col_q;
      res_fdone_q <= ({1'b0, row_q} == OcntW'(n_outer - 1'b1)) &&
                     ({1'b0, col_q} == IcntW'(n_inner - 1'b1));
    end
  end

  // Quotient estimate by reciprocal
  always_comb begin
    for (int c = 0; c < 3; c++) prod[c] = sum_q[c] * mrec;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      for (int c = 0; c < 3; c++) q0_q[c] <= prod[c][SumW+24-1:24];
    end
  end

  // Correct the estimate by one and saturate
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      back[c] = q0_q[c] * area;
      rem[c]  = (SumW+1)'({1'b0, sum_q[c]} - back[c][SumW:0]);
      qc[c]   = (rem[c] >= (SumW+1)'(area)) ? {1'b0, q0_q[c]} + 1'b1 : {1'b0, q0_q[c]};
      avg[c]  = (qc[c] > (SumW+1)'(255)) ? 8'hFF : qc[c][7:0];
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      avg_q   <= avg;
      opos_q  <= res_row_q;
      ipos_q  <= res_col_q;
      fdone_q <= res_fdone_q;
    end
  end

  assign sts_o.dirty     = dirty_q;
  assign sts_o.div_done  = div_done;
  assign sts_o.block_end = block_end;
  assign sts_o.out_free  = out_free;

  assign out_valid_o     = out_valid_q;
  assign avg_red_o       = avg_q[0];
  assign avg_green_o     = avg_q[1];
  assign avg_blue_o      = avg_q[2];
  assign out_outer_pos_o = opos_q;
  assign out_inner_pos_o = ipos_q;
  assign frame_done_o    = fdone_q;

`ifndef SYNTHESIS
  a_sub_in_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !dirty_q |-> ({1'b0, subc_q} < f_eff && {1'b0, subr_q} < f_eff))
    else $error("block position beyond scale factor");
`endif

endmodule
`default_nettype wire

// ----- hdl/rbd_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module rbd_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire rbd_pkg::sts_t sts_i,
  output rbd_pkg::cmd_t      cmd_o
);
  import rbd_pkg::*;

  state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_valid_i) state_d = sts_i.dirty ? S_DIV : S_READ;
      S_DIV:  if (sts_i.div_done) state_d = S_READ;
      S_READ: state_d = S_SUM;
      S_SUM:  state_d = sts_i.block_end ? S_MUL : S_IDLE;
      S_MUL:  state_d = S_CORR;
      S_CORR: if (sts_i.out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  // Commands
  always_comb begin
    cmd_o          = '0;
    in_ready_o     = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      S_READ: cmd_o.rd_en  = 1'b1;
      S_SUM:  cmd_o.sum_en = 1'b1;
      S_MUL:  cmd_o.mul_en = 1'b1;
      S_CORR: cmd_o.out_load = sts_i.out_free;
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_corr_leaves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CORR && sts_i.out_free) |=> (state_q == S_IDLE))
    else $error("result transfer did not return to idle");
  a_clean_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && in_valid_i && !sts_i.dirty) |=> (state_q == S_READ))
    else $error("accepted pixel did not go to memory read");
`endif

endmodule
`default_nettype wire

// ----- hdl/rgb_box_downsampler.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Result path: a block average reaches the output register after the last
// pixel's transfer via memory read, accumulate, reciprocal multiply and
// correction, which waits on a full output register; a scale factor write
// makes the next pixel first wait for the index divider. The sequencer takes
// no new pixel before the last is done; the sum line memory is single-port.
// Reset: counters to zero, sums read as zero through per-entry valid bits,
// registers to factor 1, 64 by 64 outputs; no clearing pass.
module rgb_box_downsampler (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [7:0]                  pixel_red_i,
  input  wire logic [7:0]                  pixel_green_i,
  input  wire logic [7:0]                  pixel_blue_i,
  input  wire logic                        frame_start_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic      [7:0]                  avg_red_o,
  output logic      [7:0]                  avg_green_o,
  output logic      [7:0]                  avg_blue_o,
  output logic      [11:0]                 out_outer_pos_o,
  output logic      [7:0]                  out_inner_pos_o,
  output logic                             frame_done_o,
  input  wire logic                        cfg_we_i,
  input  wire logic [rbd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [rbd_pkg::CfgW-1:0]    cfg_data_i
);
  import rbd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rbd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rbd_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .pixel_red_i     (pixel_red_i),
    .pixel_green_i   (pixel_green_i),
    .pixel_blue_i    (pixel_blue_i),
    .frame_start_i   (frame_start_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .avg_red_o       (avg_red_o),
    .avg_green_o     (avg_green_o),
    .avg_blue_o      (avg_blue_o),
    .out_outer_pos_o (out_outer_pos_o),
    .out_inner_pos_o (out_inner_pos_o),
    .frame_done_o    (frame_done_o)
  );

endmodule
`default_nettype wire
